>>> hdl/hel_pkg.sv
// shared types, constants and character helpers for the hex escape line encoder
package hel_pkg;

	localparam int MAX_LINE  = 16;
	localparam int LEN_W     = $clog2(MAX_LINE + 1);
	localparam int IDX_W     = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
	localparam int RAM_DEPTH = 2 * MAX_LINE;
	localparam int ADDR_W    = $clog2(RAM_DEPTH);
	localparam int LIMIT_W   = 40;
	localparam int PREFIX_N  = 5;

	localparam logic [7:0] CH_COLON   = 8'h3a;
	localparam logic [7:0] CH_CLOSE   = 8'h5d;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_DEL     = 8'h7f;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             esc;
		logic             ovf;
	} hel_desc_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} hel_wr_t;

	// "$HEX[" one character at a time
	function automatic logic [7:0] prefix_char(input logic [2:0] k);
		logic [7:0] c;
		unique case (k)
			3'd0:    c = 8'h24;
			3'd1:    c = 8'h48;
			3'd2:    c = 8'h45;
			3'd3:    c = 8'h58;
			3'd4:    c = 8'h5b;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// lower-case hex digit
	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = 8'h30 + {4'h0, d};
		end else begin
			c = 8'h57 + {4'h0, d};
		end
		return c;
	endfunction

	function automatic logic [ADDR_W-1:0] bank_addr(input logic bank,
			input logic [IDX_W-1:0] idx);
		logic [ADDR_W-1:0] a;
		a = ADDR_W'(idx);
		if (bank) begin
			a = a + ADDR_W'(MAX_LINE);
		end
		return a;
	endfunction

endpackage

>>> hdl/hel_if.sv
// valid/ready channel interfaces for line bytes in and characters out
interface hel_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] line_byte;
	logic       byte_present;
	logic       end_of_line;

	modport source (output valid, line_byte, byte_present, end_of_line, input ready);
	modport sink (input valid, line_byte, byte_present, end_of_line, output ready);
endinterface

interface hel_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       line_done;
	logic       truncated;

	modport source (output valid, out_char, line_done, truncated, input ready);
	modport sink (input valid, out_char, line_done, truncated, output ready);
endinterface

>>> hdl/hel_ram.sv
// generic single write port, single read port ram with registered read
module hel_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/hel_front.sv
// front end: takes line words, classifies the line and writes its bytes to the store
module hel_front
	import hel_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	hel_in_if.sink     line_in,
	input  logic       q_full,
	output logic       q_push,
	output hel_desc_t  q_desc,
	output hel_wr_t    wr
);

	logic [LEN_W-1:0] len_q;
	logic             esc_q;
	logic [2:0]       pm_q;
	logic             ovf_q;
	logic             bank_q;

	logic             acc;
	logic             store_byte;
	logic [7:0]       b;
	logic [LEN_W-1:0] len_d;
	logic             esc_d;
	logic [2:0]       pm_d;
	logic             ovf_d;

	// a line's bank stays busy until the back end has sent or dropped it
	assign line_in.ready = !q_full;
	assign acc = line_in.valid && line_in.ready;
	assign b = line_in.line_byte;
	assign store_byte = acc && line_in.byte_present && (len_q < LEN_W'(MAX_LINE));

	always_comb begin
		len_d = len_q;
		esc_d = esc_q;
		pm_d  = pm_q;
		ovf_d = ovf_q;
		if (store_byte) begin
			if (b < CH_SPACE || b >= CH_DEL || b == CH_COLON) begin
				esc_d = 1'b1;
			end
			if (pm_q < 3'(PREFIX_N) && (LEN_W+3)'(len_q) == (LEN_W+3)'(pm_q)
					&& b == prefix_char(pm_q)) begin
				pm_d = pm_q + 3'd1;
			end
			len_d = len_q + LEN_W'(1);
		end else if (acc && line_in.byte_present) begin
			ovf_d = 1'b1;
		end
	end

	assign wr.we   = store_byte;
	assign wr.addr = bank_addr(bank_q, len_q[IDX_W-1:0]);
	assign wr.data = b;

	assign q_push      = acc && line_in.end_of_line;
	assign q_desc.len  = len_d;
	assign q_desc.esc  = esc_d || (pm_d == 3'(PREFIX_N));
	assign q_desc.ovf  = ovf_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			esc_q  <= 1'b0;
			pm_q   <= '0;
			ovf_q  <= 1'b0;
			bank_q <= 1'b0;
		end else if (q_push) begin
			len_q  <= '0;
			esc_q  <= 1'b0;
			pm_q   <= '0;
			ovf_q  <= 1'b0;
			bank_q <= !bank_q;
		end else begin
			len_q <= len_d;
			esc_q <= esc_d;
			pm_q  <= pm_d;
			ovf_q <= ovf_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_LINE))
		else $error("front line length beyond capacity");
`endif

endmodule

>>> hdl/hel_line_q.sv
// two-entry queue of finished line descriptors, one per store bank
module hel_line_q
	import hel_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  hel_desc_t push_desc,
	input  logic      pop,
	output hel_desc_t head,
	output logic      full,
	output logic      empty
);

	hel_desc_t  ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("line queue push while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("line queue pop while empty");
`endif

endmodule

>>> hdl/hel_back.sv
// back end: sends a stored line raw or hex escaped, or drops it past the line limit
module hel_back
	import hel_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               line_limit_we,
	input  logic [LIMIT_W-1:0] line_limit_wd,
	input  hel_desc_t          q_head,
	input  logic               q_empty,
	output logic               q_pop,
	output logic               ren,
	output logic [ADDR_W-1:0]  raddr,
	input  logic [7:0]         rdata,
	hel_out_if.source          char_out
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREFIX,
		ST_FETCH,
		ST_HI,
		ST_LO,
		ST_RAW,
		ST_CLOSE,
		ST_NL
	} state_t;

	state_t             state_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   idx_q;
	logic               esc_q;
	logic               ovf_q;
	logic [2:0]         k_q;
	logic               bank_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [LIMIT_W-1:0] sent_q;
	logic               stopped_q;
	logic               out_valid_q;
	logic [7:0]         out_char_q;
	logic               out_done_q;
	logic               out_trunc_q;

	logic               can_emit;
	logic               emit;
	logic [7:0]         emit_char;
	logic               last_byte;
	logic [LIMIT_W-1:0] sent_inc;

	assign can_emit  = !out_valid_q || char_out.ready;
	assign last_byte = (idx_q + LEN_W'(1)) == len_q;
	assign sent_inc  = sent_q + LIMIT_W'(1);

	always_comb begin
		emit      = 1'b0;
		emit_char = CH_NEWLINE;
		case (state_q)
			ST_PREFIX: begin
				emit      = can_emit;
				emit_char = prefix_char(k_q);
			end
			ST_HI: begin
				emit      = can_emit;
				emit_char = hex_char(rdata[7:4]);
			end
			ST_LO: begin
				emit      = can_emit;
				emit_char = hex_char(rdata[3:0]);
			end
			ST_RAW: begin
				emit      = can_emit;
				emit_char = rdata;
			end
			ST_CLOSE: begin
				emit      = can_emit;
				emit_char = CH_CLOSE;
			end
			ST_NL: begin
				emit      = can_emit;
				emit_char = CH_NEWLINE;
			end
			default: begin
				emit      = 1'b0;
				emit_char = CH_NEWLINE;
			end
		endcase
	end

	// the bank is released once the line is sent, or at once when stopped
	assign q_pop = (state_q == ST_IDLE && !q_empty && stopped_q) || (state_q == ST_NL && emit);
	assign ren   = (state_q == ST_FETCH);
	assign raddr = bank_addr(bank_q, idx_q[IDX_W-1:0]);

	assign char_out.valid     = out_valid_q;
	assign char_out.out_char  = out_char_q;
	assign char_out.line_done = out_done_q;
	assign char_out.truncated = out_trunc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			idx_q       <= '0;
			esc_q       <= 1'b0;
			ovf_q       <= 1'b0;
			k_q         <= '0;
			bank_q      <= 1'b0;
			limit_q     <= '0;
			sent_q      <= '0;
			stopped_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_done_q  <= 1'b0;
			out_trunc_q <= 1'b0;
		end else begin
			if (line_limit_we) begin
				limit_q <= line_limit_wd;
			end

			if (emit) begin
				out_valid_q <= 1'b1;
				out_char_q  <= emit_char;
				out_done_q  <= (state_q == ST_NL);
				out_trunc_q <= ovf_q;
			end else if (char_out.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						len_q <= q_head.len;
						esc_q <= q_head.esc;
						ovf_q <= q_head.ovf;
						idx_q <= '0;
						k_q   <= '0;
						if (stopped_q) begin
							bank_q <= !bank_q;
						end else if (q_head.esc) begin
							state_q <= ST_PREFIX;
						end else if (q_head.len == '0) begin
							state_q <= ST_NL;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_PREFIX: begin
					if (emit) begin
						k_q <= k_q + 3'd1;
						if (k_q == 3'(PREFIX_N - 1)) begin
							state_q <= (len_q == '0) ? ST_CLOSE : ST_FETCH;
						end
					end
				end
				ST_FETCH: begin
					state_q <= esc_q ? ST_HI : ST_RAW;
				end
				ST_HI: begin
					if (emit) begin
						state_q <= ST_LO;
					end
				end
				ST_LO: begin
					if (emit) begin
						idx_q   <= idx_q + LEN_W'(1);
						state_q <= last_byte ? ST_CLOSE : ST_FETCH;
					end
				end
				ST_RAW: begin
					if (emit) begin
						idx_q   <= idx_q + LEN_W'(1);
						state_q <= last_byte ? ST_NL : ST_FETCH;
					end
				end
				ST_CLOSE: begin
					if (emit) begin
						state_q <= ST_NL;
					end
				end
				ST_NL: begin
					if (emit) begin
						sent_q  <= sent_inc;
						bank_q  <= !bank_q;
						state_q <= ST_IDLE;
						if (limit_q != '0 && sent_inc >= limit_q) begin
							stopped_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_stop_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(stopped_q))
		else $error("stop flag cleared without reset");
	a_fetch_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FETCH |-> idx_q < len_q)
		else $error("store read past line length");
	a_done_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NL && emit) |=> sent_q == $past(sent_inc))
		else $error("line count not advanced on newline");
`endif

endmodule

>>> hdl/hex_escape_line_encoder_core.sv
// top level of the hex escape line encoder: front end, line queue, store and back end
//
//   channel     dir  words                              handshake
//   line_in     in   line_byte, byte_present, eol       valid/ready
//   char_out    out  out_char, line_done, truncated     valid/ready
//   line_limit  in   40-bit limit                       write enable, no read-back
//
// front takes one word per cycle while one of the two store banks is free
// back sends an escaped line as $HEX[, a store read and two hex digits per byte, ]
// and newline; a raw line as a store read and the byte itself per byte, then newline
// a line past the limit is released by the back end and sends nothing
// arst_n clears all control state; store contents are not reset
// a stalled char_out holds the back end; the front keeps filling the other bank
module hex_escape_line_encoder_core
	import hel_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	hel_in_if.sink             line_in,
	hel_out_if.source          char_out,
	input  logic               line_limit_we,
	input  logic [LIMIT_W-1:0] line_limit_wd
);

	logic              q_full;
	logic              q_empty;
	logic              q_push;
	logic              q_pop;
	hel_desc_t         q_desc;
	hel_desc_t         q_head;
	hel_wr_t           wr;
	logic              ren;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        rdata;

	hel_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.line_in (line_in),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_desc  (q_desc),
		.wr      (wr)
	);

	hel_line_q u_line_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (q_desc),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	hel_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (ren),
		.raddr (raddr),
		.rdata (rdata)
	);

	hel_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.line_limit_we (line_limit_we),
		.line_limit_wd (line_limit_wd),
		.q_head        (q_head),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.ren           (ren),
		.raddr         (raddr),
		.rdata         (rdata),
		.char_out      (char_out)
	);

endmodule

>>> dv/hel_char_checker.sv
// scoreboard for the hex escape line encoder: predicts char_out from accepted line words
module hel_char_checker
	import hel_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	hel_in_if                  line_in,
	hel_out_if                 char_out,
	input  logic               line_limit_we,
	input  logic [LIMIT_W-1:0] line_limit_wd,
	output int unsigned        chars_pending,
	output int unsigned        mismatches
);

	typedef struct packed {
		logic [7:0] ch;
		logic       done;
		logic       trunc;
	} char_word_t;

	localparam logic [8*PREFIX_N-1:0] HEX_TAG    = "$HEX[";
	localparam logic [127:0]          HEX_DIGITS = "0123456789abcdef";

	logic [7:0]         held_bytes [MAX_LINE];
	int                 held_len;
	int                 prefix_seen;
	logic               escape_line;
	logic               dropped;
	logic               halted;
	logic [LIMIT_W-1:0] sent_count;
	logic [LIMIT_W-1:0] limit_q;
	char_word_t         expected_chars [$];

	function automatic logic [7:0] tag_char(input int k);
		return HEX_TAG[8*(PREFIX_N-1-k) +: 8];
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		return HEX_DIGITS[8*(15-int'(d)) +: 8];
	endfunction

	task automatic queue_char(input logic [7:0] c, input logic done);
		expected_chars.push_back('{c, done, dropped});
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [7:0] b;
		char_word_t got;
		char_word_t want;
		if (!arst_n) begin
			held_len    = 0;
			prefix_seen = 0;
			escape_line = 1'b0;
			dropped     = 1'b0;
			halted      = 1'b0;
			sent_count  = '0;
			limit_q     = '0;
			mismatches  = 0;
			expected_chars.delete();
		end else begin
			if (line_limit_we) begin
				limit_q = line_limit_wd;
			end
			if (line_in.valid && line_in.ready) begin
				if (line_in.byte_present) begin
					b = line_in.line_byte;
					// bytes past capacity are never sent, so they do not steer the escape choice
					if (held_len < MAX_LINE) begin
						if (b < CH_SPACE || b >= CH_DEL || b == CH_COLON) begin
							escape_line = 1'b1;
						end
						if (prefix_seen < PREFIX_N && held_len == prefix_seen &&
								b == tag_char(prefix_seen)) begin
							prefix_seen++;
						end
						held_bytes[held_len] = b;
						held_len++;
					end else begin
						dropped = 1'b1;
					end
				end
				if (line_in.end_of_line) begin
					if (!halted) begin
						if (escape_line || prefix_seen == PREFIX_N) begin
							for (int i = 0; i < PREFIX_N; i++) begin
								queue_char(tag_char(i), 1'b0);
							end
							for (int i = 0; i < held_len; i++) begin
								queue_char(digit_char(held_bytes[i][7:4]), 1'b0);
								queue_char(digit_char(held_bytes[i][3:0]), 1'b0);
							end
							queue_char(CH_CLOSE, 1'b0);
						end else begin
							for (int i = 0; i < held_len; i++) begin
								queue_char(held_bytes[i], 1'b0);
							end
						end
						queue_char(CH_NEWLINE, 1'b1);
						sent_count = sent_count + 1'b1;
						// limit is only looked at after a line has gone out
						if (limit_q != '0 && sent_count >= limit_q) begin
							halted = 1'b1;
						end
					end
					held_len    = 0;
					prefix_seen = 0;
					escape_line = 1'b0;
					dropped     = 1'b0;
				end
			end
			if (char_out.valid && char_out.ready) begin
				got = '{char_out.out_char, char_out.line_done, char_out.truncated};
				if (expected_chars.size() == 0) begin
					$error("out_char: expected none, got %02h", got.ch);
					mismatches++;
				end else begin
					want = expected_chars.pop_front();
					if (got.ch !== want.ch) begin
						$error("out_char: expected %02h, got %02h", want.ch, got.ch);
						mismatches++;
					end
					if (got.done !== want.done) begin
						$error("line_done: expected %0b, got %0b", want.done, got.done);
						mismatches++;
					end
					if (got.trunc !== want.trunc) begin
						$error("truncated: expected %0b, got %0b", want.trunc, got.trunc);
						mismatches++;
					end
				end
			end
		end
		chars_pending = expected_chars.size();
	end

endmodule

>>> dv/tb_top.sv
// testbench top for the hex escape line encoder: clock, reset, line stimulus and verdict
module tb_top;
	import hel_pkg::*;

	localparam logic [8*PREFIX_N-1:0] HEX_TAG   = "$HEX[";
	localparam logic [LIMIT_W-1:0]    LIMIT_MAX = '1;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               line_limit_we;
	logic [LIMIT_W-1:0] line_limit_wd;
	int unsigned        pending_chars;
	int unsigned        mismatches;

	bit tx_idle;
	bit rx_idle;
	bit stall_request;
	bit stall_done;
	int items_sent;
	int lines_ended;

	hel_in_if  line_in();
	hel_out_if char_out();

	hex_escape_line_encoder_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.line_in       (line_in),
		.char_out      (char_out),
		.line_limit_we (line_limit_we),
		.line_limit_wd (line_limit_wd)
	);

	hel_char_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.line_in       (line_in),
		.char_out      (char_out),
		.line_limit_we (line_limit_we),
		.line_limit_wd (line_limit_wd),
		.chars_pending (pending_chars),
		.mismatches    (mismatches)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic put_word(input logic [7:0] b, input logic present, input logic eol);
		while (tx_idle && $urandom_range(0, 99) < 10) begin
			line_in.valid = 1'b0;
			@(negedge clk);
		end
		line_in.valid        = 1'b1;
		line_in.line_byte    = b;
		line_in.byte_present = present;
		line_in.end_of_line  = eol;
		do begin
			@(posedge clk);
		end while (!line_in.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		line_in.valid = 1'b0;
		while (pending_chars != 0) begin
			@(negedge clk);
		end
		// lines past the limit are still released by the back end with nothing to show
		repeat (100) @(negedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		line_limit_we = 1'b1;
		line_limit_wd = value;
		@(negedge clk);
		line_limit_we = 1'b0;
	endtask

	function automatic logic [7:0] printable();
		logic [7:0] c;
		c = 8'($urandom_range(CH_SPACE, CH_DEL - 1));
		if (c == CH_COLON) begin
			c = 8'h3b;
		end
		return c;
	endfunction

	task automatic send_random_line();
		int         kind;
		int         len;
		int         n_pre;
		int         offset;
		int         odd_at;
		int         pick;
		bit         noisy;
		bit         split_end;
		logic [7:0] b;
		kind      = $urandom_range(0, 9);
		len       = (kind == 9) ? $urandom_range(MAX_LINE + 1, MAX_LINE + 6)
				: $urandom_range(0, MAX_LINE);
		n_pre     = $urandom_range(1, PREFIX_N);
		offset    = (kind == 7) ? $urandom_range(0, 1) : 0;
		odd_at    = (len > 0) ? $urandom_range(0, len - 1) : 0;
		noisy     = $urandom_range(0, 1);
		split_end = (len == 0) || ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++) begin
			b = printable();
			case (kind)
				4, 5: begin
					b = 8'($urandom);
				end
				6, 7: begin
					// whole or partial tag, sometimes shifted off the line start
					if (i >= offset && i - offset < n_pre) begin
						b = HEX_TAG[8*(PREFIX_N-1-(i-offset)) +: 8];
					end
				end
				8: begin
					if (i == odd_at) begin
						pick = $urandom_range(0, 2);
						b = (pick == 0) ? 8'($urandom_range(0, CH_SPACE - 1))
								: (pick == 1) ? 8'($urandom_range(CH_DEL, 8'hff)) : CH_COLON;
					end
				end
				9: begin
					if (noisy || i >= MAX_LINE) begin
						b = 8'($urandom);
					end
				end
				default: begin
				end
			endcase
			if ($urandom_range(0, 99) < 4) begin
				put_word(8'($urandom), 1'b0, 1'b0);
			end
			put_word(b, 1'b1, !split_end && i == len - 1);
		end
		if (split_end) begin
			put_word(8'($urandom), 1'b0, 1'b1);
		end
		items_sent += len + int'(split_end);
		lines_ended++;
	endtask

	// receiver: random back-pressure plus one long hold-off on request
	initial begin
		char_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request) begin
				stall_request  = 1'b0;
				char_out.ready = 1'b0;
				repeat (400) @(negedge clk);
			end
			char_out.ready = !rx_idle || $urandom_range(0, 99) >= 10;
		end
	end

	initial begin
		#3_000_000;
		$display("hex_escape_line_encoder_core: mismatch");
		$finish;
	end

	initial begin
		line_in.valid        = 1'b0;
		line_in.line_byte    = '0;
		line_in.byte_present = 1'b0;
		line_in.end_of_line  = 1'b0;
		line_limit_we        = 1'b0;
		line_limit_wd        = '0;
		tx_idle              = 1'b1;
		rx_idle              = 1'b1;
		stall_request        = 1'b0;
		stall_done           = 1'b0;
		items_sent           = 0;
		lines_ended          = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		write_limit('0);

		// directed lines
		put_word(8'h55, 1'b0, 1'b0);
		put_word(8'haa, 1'b0, 1'b1);
		for (int i = 0; i < PREFIX_N; i++) begin
			put_word(HEX_TAG[8*(PREFIX_N-1-i) +: 8], 1'b1, i == PREFIX_N - 1);
		end
		put_word(CH_SPACE - 8'd1, 1'b1, 1'b1);
		put_word(CH_DEL, 1'b1, 1'b1);
		put_word(CH_COLON, 1'b1, 1'b1);
		put_word(CH_SPACE, 1'b1, 1'b0);
		put_word(CH_DEL - 8'd1, 1'b1, 1'b1);
		put_word(8'h00, 1'b1, 1'b0);
		put_word(8'hff, 1'b1, 1'b1);
		// full line of plain text, then a colon that gets dropped
		for (int i = 0; i < MAX_LINE; i++) begin
			put_word(8'h61 + 8'(i), 1'b1, 1'b0);
		end
		put_word(CH_COLON, 1'b1, 1'b1);
		items_sent  = 31;
		lines_ended = 8;
		wait_drained();

		while (items_sent < 130) begin
			if (!stall_done && items_sent >= 70) begin
				stall_request = 1'b1;
				stall_done    = 1'b1;
			end
			send_random_line();
		end
		wait_drained();

		write_limit(LIMIT_MAX);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		while (items_sent < 190) begin
			send_random_line();
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		while (items_sent < 230) begin
			send_random_line();
		end
		wait_drained();

		// one line short of the limit, then lower it below the count
		write_limit(LIMIT_W'(lines_ended + 2));
		send_random_line();
		wait_drained();
		write_limit(LIMIT_W'(1));
		while (items_sent < 260) begin
			send_random_line();
		end
		wait_drained();

		if (mismatches == 0) begin
			$display("hex_escape_line_encoder_core: match");
		end else begin
			$display("hex_escape_line_encoder_core: mismatch");
		end
		$finish;
	end

endmodule

>>> files.f
hdl/hel_pkg.sv
hdl/hel_if.sv
hdl/hel_ram.sv
hdl/hel_front.sv
hdl/hel_line_q.sv
hdl/hel_back.sv
hdl/hex_escape_line_encoder_core.sv
dv/hel_char_checker.sv
dv/tb_top.sv
